// ===== design/crc8wr_pkg.sv =====
package crc8wr_pkg;

  // Default word limit of one reply.
  localparam int MAX_WORDS_DEF = 16;

  // CRC-8 setup: polynomial x^8 + x^5 + x^4 + 1, register preset to all ones.
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Position of a byte inside its triplet.
  typedef enum logic [1:0] {
    PHASE_HIGH = 2'd0,
    PHASE_LOW  = 2'd1,
    PHASE_CRC  = 2'd2
  } phase_t;

  // One registered input transaction handed to the framing stage.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
  } item_t;

  // One byte through the CRC, MSB first. Unrolls to a small XOR network.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/crc8wr_if.sv =====
interface crc8wr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       reply_last;

  modport source (output valid, output reply_byte, output reply_last, input ready);
  modport sink (input valid, input reply_byte, input reply_last, output ready);
endinterface

interface crc8wr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] word_value;
  logic [3:0]  word_number;
  logic        crc_ok;
  logic        frame_end;
  logic        frame_ok;
  logic        length_error;

  modport source (output valid, output word_value, output word_number, output crc_ok,
                  output frame_end, output frame_ok, output length_error, input ready);
  modport sink (input valid, input word_value, input word_number, input crc_ok,
                input frame_end, input frame_ok, input length_error, output ready);
endinterface

// ===== design/crc8wr_in_stage.sv =====
module crc8wr_in_stage (
  input  logic               clk,
  input  logic               rst,
  crc8wr_in_if.sink          byte_in,
  input  logic               slot_free,
  output crc8wr_pkg::item_t  item
);

  crc8wr_pkg::item_t held;

  // The register takes a new byte when empty or when its current byte moves on.
  assign byte_in.ready = !held.vld || slot_free;
  assign item = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.vld <= 1'b0;
    end else if (byte_in.ready) begin
      held.vld <= byte_in.valid;
    end
    if (byte_in.ready && byte_in.valid) begin
      held.data <= byte_in.reply_byte;
      held.last <= byte_in.reply_last;
    end
  end

endmodule

// ===== design/crc8wr_frame.sv =====
module crc8wr_frame #(
  parameter int MAX_WORDS = crc8wr_pkg::MAX_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  crc8wr_pkg::item_t  item,
  output logic               slot_free,
  crc8wr_out_if.source       word_out
);

  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam logic [CW-1:0] LIMIT = CW'(MAX_WORDS);
  localparam logic [CW-1:0] LAST_IDX = CW'(MAX_WORDS - 1);

  crc8wr_pkg::phase_t byte_phase;
  logic [7:0]    high_byte;
  logic [7:0]    low_hold;
  logic [7:0]    crc_running;
  logic [CW-1:0] word_count;
  logic          frame_good;
  logic          overflow_seen;

  logic          step;
  logic          emit;
  logic [7:0]    crc_seed;
  logic [7:0]    crc_next;
  logic          ok;
  logic          at_limit;
  logic [CW-1:0] idx;
  logic [CW+3:0] idx_ext;
  logic [CW+3:0] cnt_ext;
  logic          good_next;
  logic          over_next;

  assign slot_free = !word_out.valid || word_out.ready;
  assign step      = item.vld && slot_free;
  // A result leaves on every CRC byte and on any byte that closes the reply.
  assign emit      = step && ((byte_phase == crc8wr_pkg::PHASE_CRC) || item.last);

  assign crc_seed  = (byte_phase == crc8wr_pkg::PHASE_HIGH) ? crc8wr_pkg::CRC_INIT
                                                            : crc_running;
  assign crc_next  = crc8wr_pkg::crc8_byte(crc_seed, item.data);
  assign ok        = (crc_running == item.data);
  assign at_limit  = (word_count >= LIMIT);
  assign idx       = at_limit ? LAST_IDX : word_count;
  assign idx_ext   = {4'b0, idx};
  assign cnt_ext   = {4'b0, word_count};
  assign good_next = frame_good && ok;
  assign over_next = overflow_seen || at_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase     <= crc8wr_pkg::PHASE_HIGH;
      crc_running    <= crc8wr_pkg::CRC_INIT;
      word_count     <= '0;
      frame_good     <= 1'b1;
      overflow_seen  <= 1'b0;
      word_out.valid <= 1'b0;
    end else begin
      if (emit) begin
        word_out.valid <= 1'b1;
      end else if (word_out.ready) begin
        word_out.valid <= 1'b0;
      end

      if (step) begin
        if (byte_phase == crc8wr_pkg::PHASE_HIGH) begin
          high_byte <= item.data;
        end
        if (byte_phase == crc8wr_pkg::PHASE_LOW) begin
          low_hold <= item.data;
        end

        if (item.last) begin
          byte_phase    <= crc8wr_pkg::PHASE_HIGH;
          crc_running   <= crc8wr_pkg::CRC_INIT;
          word_count    <= '0;
          frame_good    <= 1'b1;
          overflow_seen <= 1'b0;
        end else begin
          unique case (byte_phase)
            crc8wr_pkg::PHASE_HIGH: begin
              crc_running <= crc_next;
              byte_phase  <= crc8wr_pkg::PHASE_LOW;
            end
            crc8wr_pkg::PHASE_LOW: begin
              crc_running <= crc_next;
              byte_phase  <= crc8wr_pkg::PHASE_CRC;
            end
            default: begin
              byte_phase    <= crc8wr_pkg::PHASE_HIGH;
              crc_running   <= crc8wr_pkg::CRC_INIT;
              frame_good    <= good_next;
              overflow_seen <= over_next;
              if (!at_limit) begin
                word_count <= word_count + CW'(1);
              end
            end
          endcase
        end
      end

      if (emit) begin
        if (byte_phase == crc8wr_pkg::PHASE_CRC) begin
          word_out.word_value   <= {high_byte, low_hold};
          word_out.word_number  <= idx_ext[3:0];
          word_out.crc_ok       <= ok;
          word_out.frame_end    <= item.last;
          word_out.frame_ok     <= item.last && good_next && !over_next;
          word_out.length_error <= item.last && over_next;
        end else begin
          // Reply stopped partway through a triplet.
          word_out.word_value   <= '0;
          word_out.word_number  <= cnt_ext[3:0];
          word_out.crc_ok       <= 1'b0;
          word_out.frame_end    <= 1'b1;
          word_out.frame_ok     <= 1'b0;
          word_out.length_error <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/crc8_word_reply_checker_core.sv =====
// Channel    Direction  Handshake      Payload
// byte_in    in         valid/ready    reply_byte[7:0], reply_last
// word_out   out        valid/ready    word_value[15:0], word_number[3:0], crc_ok,
//                                      frame_end, frame_ok, length_error
//
// One byte is accepted every cycle while results are being taken; each byte passes
// first through the input register and then through the framing stage, whose
// result register feeds word_out.
// The per-byte CRC update is a single eight-step XOR network between the two registers.
// Reset (rst, synchronous) empties both registers and restarts the frame state.
// A stalled word_out holds its result; byte_in keeps accepting until the input
// register is also full, and every byte, even one that causes no result, waits
// in the input register until the result register is free.
module crc8_word_reply_checker_core #(
  parameter int MAX_WORDS = crc8wr_pkg::MAX_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  crc8wr_in_if.sink     byte_in,
  crc8wr_out_if.source  word_out
);

  // Registered transaction from the input stage and the framing stage's
  // permission to move it forward.
  crc8wr_pkg::item_t item;
  logic              slot_free;

  // Input register: decouples the byte source from the result side.
  crc8wr_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .slot_free (slot_free),
    .item      (item)
  );

  // Triplet framing, CRC check, word counting and the result register.
  crc8wr_frame #(
    .MAX_WORDS (MAX_WORDS)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .slot_free (slot_free),
    .word_out  (word_out)
  );

endmodule

// ===== design/crc8wr_checker.sv =====
module crc8wr_checker (
  input logic clk,
  input logic rst,
  input logic word_valid,
  input logic word_ready,
  input logic crc_ok,
  input logic frame_end,
  input logic frame_ok,
  input logic length_error
);

  // A passing frame requires the closing word to pass its own CRC.
  a_ok_needs_crc: assert property (@(posedge clk) disable iff (rst)
    word_valid && frame_ok |-> frame_end && crc_ok)
    else $error("frame_ok without a passing closing word");

  // Frame status flags only appear on the closing result and exclude each other.
  a_flags_at_end: assert property (@(posedge clk) disable iff (rst)
    word_valid && (frame_ok || length_error) |-> frame_end && !(frame_ok && length_error))
    else $error("frame status outside frame end or contradictory");

  // No result right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !word_valid)
    else $error("result valid after reset");

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_ready |=> word_valid)
    else $error("result dropped while stalled");

endmodule

bind crc8_word_reply_checker_core crc8wr_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .word_valid   (word_out.valid),
  .word_ready   (word_out.ready),
  .crc_ok       (word_out.crc_ok),
  .frame_end    (word_out.frame_end),
  .frame_ok     (word_out.frame_ok),
  .length_error (word_out.length_error)
);

// ===== bench/crc8_word_reply_checker_core_test.sv =====
module crc8_word_reply_checker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The bench runs the block at its default word limit.
  // The prediction below uses the same value.
  localparam int WORD_LIMIT = crc8wr_pkg::MAX_WORDS_DEF;

  // The run is stopped when this many cycles in a row pass with no transaction on
  // either channel. The longest correct quiet stretch is the receiver hold-off
  // plus one idle burst, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 2000;

  // The receiver holds off once for this many cycles. It starts after this many
  // bytes have been taken.
  localparam int HOLD_CYCLES = 48;
  localparam int HOLD_AFTER  = 150;

  // The number of input bytes that the stimulus aims for.
  localparam int BYTE_TARGET = 450;

  // When fewer bytes than this are still waiting to be sent, both sides stop idling.
  localparam int CALM_TAIL = 80;

  // Only the first few mismatches are printed. Later ones are only counted.
  localparam int SHOW_LIMIT = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_byte_t;

  typedef struct packed {
    logic [15:0] value;
    logic [3:0]  number;
    logic        crc_ok;
    logic        frame_end;
    logic        frame_ok;
    logic        length_error;
  } word_report_t;

  logic clk;
  logic rst;

  crc8wr_in_if  byte_if ();
  crc8wr_out_if word_if ();

  crc8_word_reply_checker_core #(
    .MAX_WORDS (WORD_LIMIT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_if),
    .word_out (word_if)
  );

  // Bytes that are still to be offered, and the word reports that the block still owes.
  reply_byte_t  bytes_to_send[$];
  word_report_t reports_due[$];

  // This is the copy of the framing state that the bench keeps for its prediction.
  crc8wr_pkg::phase_t trip_pos;
  logic [7:0]  word_hi;
  logic [7:0]  word_lo;
  logic [7:0]  crc_acc;
  int unsigned words_seen;
  bit          all_words_good;
  bit          past_limit;

  int          mismatches;
  int          bytes_taken;
  bit          calm;
  int          src_gap;
  int          sink_gap;
  int          hold_cnt;
  bit          hold_done;
  int          quiet_cycles;
  reply_byte_t next_byte;
  word_report_t got_report;
  word_report_t want_report;

  // This is the bit-serial form of the CRC, MSB first. Each data bit is folded into
  // the feedback before the shift.
  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r  = {r[6:0], 1'b0} ^ (fb ? crc8wr_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic string report_text(input word_report_t r);
    return $sformatf("word=%04h num=%0d crc_ok=%0b end=%0b frame_ok=%0b len_err=%0b",
                     r.value, r.number, r.crc_ok, r.frame_end, r.frame_ok, r.length_error);
  endfunction

  // Every reply end, good or bad, returns the frame to its start.
  task automatic frame_restart();
    trip_pos       = crc8wr_pkg::PHASE_HIGH;
    crc_acc        = crc8wr_pkg::CRC_INIT;
    words_seen     = 0;
    all_words_good = 1'b1;
    past_limit     = 1'b0;
  endtask

  // This task works out the report, if any, that one accepted byte causes.
  // It then adds that report to the reports still owed.
  task automatic predict_byte(input logic [7:0] b, input logic last);
    word_report_t r;
    bit           emitted;
    int unsigned  slot;
    r       = '0;
    emitted = 1'b0;
    case (trip_pos)
      crc8wr_pkg::PHASE_HIGH: begin
        word_hi  = b;
        crc_acc  = crc_step(crc8wr_pkg::CRC_INIT, b);
        trip_pos = crc8wr_pkg::PHASE_LOW;
      end
      crc8wr_pkg::PHASE_LOW: begin
        word_lo  = b;
        crc_acc  = crc_step(crc_acc, b);
        trip_pos = crc8wr_pkg::PHASE_CRC;
      end
      default: begin
        r.crc_ok = (crc_acc == b);
        // A word past the limit is still checked and reported, but it keeps the
        // last legal index and marks the reply as too long.
        if (words_seen >= WORD_LIMIT) begin
          past_limit = 1'b1;
          slot       = WORD_LIMIT - 1;
        end else begin
          slot       = words_seen;
          words_seen = words_seen + 1;
        end
        if (!r.crc_ok) begin
          all_words_good = 1'b0;
        end
        r.value  = {word_hi, word_lo};
        r.number = slot[3:0];
        if (last) begin
          r.frame_end    = 1'b1;
          r.frame_ok     = all_words_good && !past_limit;
          r.length_error = past_limit;
          frame_restart();
        end else begin
          trip_pos = crc8wr_pkg::PHASE_HIGH;
          crc_acc  = crc8wr_pkg::CRC_INIT;
        end
        reports_due.push_back(r);
        emitted = 1'b1;
      end
    endcase
    // A reply that stops partway through a triplet closes with an empty report
    // and a length error.
    if (last && !emitted) begin
      r.number       = words_seen[3:0];
      r.frame_end    = 1'b1;
      r.length_error = 1'b1;
      reports_due.push_back(r);
      frame_restart();
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    reply_byte_t it;
    it.data = b;
    it.last = last;
    bytes_to_send.push_back(it);
  endtask

  // This task queues one triplet. A nonzero flip mask corrupts the CRC byte.
  task automatic push_word(input logic [15:0] w, input logic [7:0] flip, input logic last);
    push_byte(w[15:8], 1'b0);
    push_byte(w[7:0], 1'b0);
    push_byte(crc_step(crc_step(crc8wr_pkg::CRC_INIT, w[15:8]), w[7:0]) ^ flip, last);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // This task queues a well-formed reply of some words. It can add a tail of one or
  // two bytes that leaves the last triplet unfinished.
  task automatic push_reply(input int words, input int bad_pct, input int tail);
    logic [7:0] flip;
    for (int i = 0; i < words; i++) begin
      flip = ($urandom_range(0, 99) < bad_pct) ? 8'($urandom_range(1, 255)) : 8'h00;
      push_word(pick_word(), flip, (tail == 0) && (i == words - 1));
    end
    for (int i = 0; i < tail; i++) begin
      push_byte(8'($urandom), i == tail - 1);
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches = mismatches + 1;
    if (mismatches <= SHOW_LIMIT) begin
      $display("%t mismatch: %s", $realtime, what);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The initial block builds the whole byte stream first. It then releases reset
  // and waits for the stream to drain.
  initial begin : stimulus
    int pick;
    int n;
    rst                 = 1'b1;
    mismatches          = 0;
    byte_if.valid       = 1'b0;
    byte_if.reply_byte  = 8'h00;
    byte_if.reply_last  = 1'b0;
    word_if.ready       = 1'b0;

    // This is the directed part.
    // The first reply is one good word.
    push_word(16'hBEEF, 8'h00, 1'b1);
    // The next reply is two words with extreme values. The second word has a bad CRC.
    push_word(16'h0000, 8'h00, 1'b0);
    push_word(16'hFFFF, 8'h01, 1'b1);
    // This reply ends right after a high byte.
    push_byte(8'hFF, 1'b1);
    // This reply has one good word and then ends after a low byte.
    push_word(16'h00FF, 8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b1);
    // This reply ends after two bytes, before its first CRC.
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    // In this reply the first CRC has every bit flipped, and a good word follows.
    push_word(16'h8001, 8'hFF, 1'b0);
    push_word(16'h7FFE, 8'h00, 1'b1);

    // These replies sit around the word limit: one exactly at it, one just over it,
    // and one over it that also ends short.
    push_reply(WORD_LIMIT, 0, 0);
    push_reply(WORD_LIMIT + 1, 0, 0);
    push_reply(WORD_LIMIT + 3, 20, 1);

    // The random part is mostly well-formed replies with random content and some bad
    // CRCs. A few replies run long. Short bursts of raw noise close with a last byte
    // so that the following reply starts in step.
    while (bytes_to_send.size() < BYTE_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          push_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 3) == 0));
        end
      end else if (pick < 12) begin
        push_reply($urandom_range(WORD_LIMIT - 1, WORD_LIMIT + 3), 5,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      end else begin
        push_reply($urandom_range(1, 5), 10,
                   ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (bytes_to_send.size() != 0 || byte_if.valid) @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
    // Give the two pipeline stages time to show any stray report.
    repeat (8) @(posedge clk);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("crc8_word_reply_checker_core regression: pass");
    end else begin
      $display("crc8_word_reply_checker_core regression: fail");
    end
    $finish;
  end

  // This is the byte sender. Each byte is predicted at the edge where its
  // transaction completes. A new byte, or an idle burst, is chosen only when the
  // channel is free.
  always @(posedge clk) begin
    if (rst) begin
      byte_if.valid <= 1'b0;
      bytes_taken   <= 0;
      calm          <= 1'b0;
      src_gap        = 0;
      word_hi        = 8'h00;
      word_lo        = 8'h00;
      frame_restart();
    end else begin
      calm <= (bytes_to_send.size() < CALM_TAIL);
      if (byte_if.valid && byte_if.ready) begin
        predict_byte(byte_if.reply_byte, byte_if.reply_last);
        bytes_taken <= bytes_taken + 1;
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (src_gap > 0) begin
          src_gap        = src_gap - 1;
          byte_if.valid <= 1'b0;
        end else if (bytes_to_send.size() == 0) begin
          byte_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          // This cycle is the first of an idle burst.
          src_gap        = $urandom_range(0, 6);
          byte_if.valid <= 1'b0;
        end else begin
          next_byte           = bytes_to_send.pop_front();
          byte_if.valid      <= 1'b1;
          byte_if.reply_byte <= next_byte.data;
          byte_if.reply_last <= next_byte.last;
        end
      end
    end
  end

  // This process counts the one long receiver hold-off. The sender keeps offering
  // bytes during it, so the input register fills and the block stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bytes_taken >= HOLD_AFTER) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // This is the report receiver and checker. Each report that is taken is checked
  // field by field against the oldest report still owed.
  always @(posedge clk) begin
    if (rst) begin
      word_if.ready <= 1'b0;
      sink_gap       = 0;
    end else begin
      if (word_if.valid && word_if.ready) begin
        got_report.value        = word_if.word_value;
        got_report.number       = word_if.word_number;
        got_report.crc_ok       = word_if.crc_ok;
        got_report.frame_end    = word_if.frame_end;
        got_report.frame_ok     = word_if.frame_ok;
        got_report.length_error = word_if.length_error;
        if (reports_due.size() == 0) begin
          note_mismatch({"unexpected report ", report_text(got_report)});
        end else begin
          want_report = reports_due.pop_front();
          if (got_report.value !== want_report.value ||
              got_report.number !== want_report.number ||
              got_report.crc_ok !== want_report.crc_ok ||
              got_report.frame_end !== want_report.frame_end ||
              got_report.frame_ok !== want_report.frame_ok ||
              got_report.length_error !== want_report.length_error) begin
            note_mismatch({"expected ", report_text(want_report),
                           " got ", report_text(got_report)});
          end
        end
      end
      if (hold_cnt != 0) begin
        word_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap       = sink_gap - 1;
        word_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_gap       = $urandom_range(0, 6);
        word_if.ready <= 1'b0;
      end else begin
        word_if.ready <= 1'b1;
      end
    end
  end

  // The watchdog ends the run if both channels stay silent for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((byte_if.valid && byte_if.ready) || (word_if.valid && word_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("crc8_word_reply_checker_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
design/crc8wr_pkg.sv
design/crc8wr_if.sv
design/crc8wr_in_stage.sv
design/crc8wr_frame.sv
design/crc8_word_reply_checker_core.sv
design/crc8wr_checker.sv
bench/crc8_word_reply_checker_core_test.sv
